/* rtl/krt_pkg.sv */
package krt_pkg;

  localparam int unsigned KeyW  = 31;
  localparam int unsigned PayW  = 32;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned StatW = 3;
  localparam int unsigned PosW  = 7;
  localparam int unsigned CapW  = 7;
  localparam int unsigned CfgIdxW = 1;

  // command codes (the unused code behaves as a search)
  localparam logic [CmdW-1:0] CMD_SEARCH = 2'd0;
  localparam logic [CmdW-1:0] CMD_INSERT = 2'd1;
  localparam logic [CmdW-1:0] CMD_REMOVE = 2'd2;

  // result status codes
  localparam logic [StatW-1:0] ST_OK    = 3'd0;
  localparam logic [StatW-1:0] ST_FULL  = 3'd1;
  localparam logic [StatW-1:0] ST_EMPTY = 3'd2;
  localparam logic [StatW-1:0] ST_DUP   = 3'd3;
  localparam logic [StatW-1:0] ST_MISS  = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ORDERED  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_CAPACITY = 1'b1;

  // per-cycle controls broadcast to every cell
  typedef struct packed {
    logic cmp;        // compare against the item key, load the conveyor
    logic tok_shift;  // conveyor moves one cell toward index 0
    logic ins;        // open a slot at pos and write the new word
    logic rem;        // close the slot at pos
    logic mv;         // cell at pos takes its conveyor word
  } krt_cell_ctrl_t;

endpackage

/* rtl/krt_cell.sv */
module krt_cell import krt_pkg::*; #(
  parameter int unsigned CW  = 7,
  parameter int unsigned IDX = 0
) (
  input  logic                clk_i,
  input  krt_cell_ctrl_t      ctrl_i,
  input  logic [CW-1:0]       pos_i,
  input  logic [CW-1:0]       bound_i,
  input  logic [KeyW-1:0]     key_i,
  input  logic [PayW-1:0]     pay_i,
  input  logic [KeyW-1:0]     lo_key_i,
  input  logic [PayW-1:0]     lo_pay_i,
  input  logic [KeyW-1:0]     hi_key_i,
  input  logic [PayW-1:0]     hi_pay_i,
  input  logic [KeyW-1:0]     hi_tok_key_i,
  input  logic [PayW-1:0]     hi_tok_pay_i,
  output logic [KeyW-1:0]     key_o,
  output logic [PayW-1:0]     pay_o,
  output logic [KeyW-1:0]     tok_key_o,
  output logic [PayW-1:0]     tok_pay_o,
  output logic                lt_o,
  output logic                eq_o
);

  localparam logic [CW-1:0] MyIdx = CW'(IDX);

  logic [KeyW-1:0] key_q, key_d, tok_key_q, tok_key_d;
  logic [PayW-1:0] pay_q, pay_d, tok_pay_q, tok_pay_d;
  logic            lt_q, lt_d, eq_q, eq_d;

  always_comb begin
    key_d     = key_q;
    pay_d     = pay_q;
    tok_key_d = tok_key_q;
    tok_pay_d = tok_pay_q;
    lt_d      = lt_q;
    eq_d      = eq_q;
    if (ctrl_i.cmp) begin
      lt_d      = key_q < key_i;
      eq_d      = key_q == key_i;
      tok_key_d = key_q;
      tok_pay_d = pay_q;
    end else if (ctrl_i.tok_shift) begin
      tok_key_d = hi_tok_key_i;
      tok_pay_d = hi_tok_pay_i;
    end
    if (ctrl_i.ins) begin
      if (MyIdx == pos_i) begin
        key_d = key_i;
        pay_d = pay_i;
      end else if (MyIdx > pos_i && MyIdx <= bound_i) begin
        key_d = lo_key_i;
        pay_d = lo_pay_i;
      end
    end else if (ctrl_i.rem) begin
      if (MyIdx >= pos_i && MyIdx < bound_i) begin
        key_d = hi_key_i;
        pay_d = hi_pay_i;
      end
    end else if (ctrl_i.mv && MyIdx == pos_i) begin
      key_d = tok_key_q;
      pay_d = tok_pay_q;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    pay_q     <= pay_d;
    tok_key_q <= tok_key_d;
    tok_pay_q <= tok_pay_d;
    lt_q      <= lt_d;
    eq_q      <= eq_d;
  end

  assign key_o     = key_q;
  assign pay_o     = pay_q;
  assign tok_key_o = tok_key_q;
  assign tok_pay_o = tok_pay_q;
  assign lt_o      = lt_q;
  assign eq_o      = eq_q;

endmodule

/* rtl/keyed_record_table_sorted_or_unsorted.sv */
// a command is latched in idle; the cells compare and the conveyor loads, the search runs
//   (binary if ordered, linear if not), the hit check decides, on a search or remove hit
//   a conveyor pass reads the payload and does the unordered move, one cell per cycle, and
//   an insert or remove writes cells and count; one command at a time, busy high meanwhile
// reset: count, mode (ordered) and capacity (64) reset at once; the record cells have no
//   reset and no clearing pass; the receiver cannot stall, done_o is a one-cycle strobe
module keyed_record_table_sorted_or_unsorted import krt_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic [CmdW-1:0]    command_i,
  input  logic [KeyW-1:0]    key_i,
  input  logic [PayW-1:0]    payload_i,
  // result channel
  output logic               done_o,
  output logic [StatW-1:0]   status_o,
  output logic [PosW-1:0]    position_o,
  output logic [PosW-1:0]    entry_count_o,
  output logic [PayW-1:0]    found_payload_o,
  // configuration writes
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CapW-1:0]    cfg_data_i
);

  localparam int unsigned CW = $clog2(DEPTH + 1);  // count and position width
  localparam int unsigned IW = $clog2(DEPTH);      // cell index width
  localparam int unsigned LW = (CW > CapW) ? CW : CapW;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;  // cells compare, conveyor loads
  localparam logic [2:0] S_SRCH = 3'd2;  // binary or linear search on cell flags
  localparam logic [2:0] S_RES  = 3'd3;  // hit check and decision
  localparam logic [2:0] S_SCAN = 3'd4;  // conveyor pass: payload read, unordered move
  localparam logic [2:0] S_WR   = 3'd5;  // shift up or down (down only when ordered), count update

  logic [2:0]       state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic             ordered_q;
  logic [CapW-1:0]  capacity_q;
  logic             done_q, done_d;

  logic [CmdW-1:0]  cmd_q, cmd_d;
  logic [KeyW-1:0]  item_key_q, item_key_d;
  logic [PayW-1:0]  item_pay_q, item_pay_d;
  logic [CW-1:0]    lo_q, lo_d, hi_q, hi_d, pos_q, pos_d;
  logic [CW-1:0]    st_q, st_d, stop_q, stop_d, lm_q, lm_d;
  logic             need_rd_q, need_rd_d, need_mv_q, need_mv_d;
  logic [PayW-1:0]  found_q, found_d;

  logic [StatW-1:0] res_status_q, res_status_d;
  logic [PosW-1:0]  res_pos_q, res_pos_d, res_cnt_q, res_cnt_d;
  logic [PayW-1:0]  res_found_q, res_found_d;

  krt_cell_ctrl_t   ctrl;
  logic [CW-1:0]    bound;

  // cell row
  logic [KeyW-1:0]  c_key [DEPTH];
  logic [PayW-1:0]  c_pay [DEPTH];
  logic [KeyW-1:0]  c_tok_key [DEPTH];
  logic [PayW-1:0]  c_tok_pay [DEPTH];
  logic [DEPTH-1:0] lt_vec, eq_vec;

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic [KeyW-1:0] lo_key, hi_key, hi_tok_key;
    logic [PayW-1:0] lo_pay, hi_pay, hi_tok_pay;
    if (gi == 0) begin : g_bot
      assign lo_key = '0;
      assign lo_pay = '0;
    end else begin : g_lo
      assign lo_key = c_key[gi-1];
      assign lo_pay = c_pay[gi-1];
    end
    if (gi == DEPTH - 1) begin : g_top
      assign hi_key     = '0;
      assign hi_pay     = '0;
      assign hi_tok_key = '0;
      assign hi_tok_pay = '0;
    end else begin : g_hi
      assign hi_key     = c_key[gi+1];
      assign hi_pay     = c_pay[gi+1];
      assign hi_tok_key = c_tok_key[gi+1];
      assign hi_tok_pay = c_tok_pay[gi+1];
    end
    krt_cell #(
      .CW  (CW),
      .IDX (gi)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .pos_i        (pos_q),
      .bound_i      (bound),
      .key_i        (item_key_q),
      .pay_i        (item_pay_q),
      .lo_key_i     (lo_key),
      .lo_pay_i     (lo_pay),
      .hi_key_i     (hi_key),
      .hi_pay_i     (hi_pay),
      .hi_tok_key_i (hi_tok_key),
      .hi_tok_pay_i (hi_tok_pay),
      .key_o        (c_key[gi]),
      .pay_o        (c_pay[gi]),
      .tok_key_o    (c_tok_key[gi]),
      .tok_pay_o    (c_tok_pay[gi]),
      .lt_o         (lt_vec[gi]),
      .eq_o         (eq_vec[gi])
    );
  end

  // command decode, anything other than insert or remove is a search
  logic is_ins, is_rem;
  assign is_ins = cmd_q == CMD_INSERT;
  assign is_rem = cmd_q == CMD_REMOVE;

  // effective limit is min(capacity, DEPTH)
  logic [LW-1:0] limit;
  logic          full;
  assign limit = (LW'(capacity_q) < LW'(DEPTH)) ? LW'(capacity_q) : LW'(DEPTH);
  assign full  = LW'(count_q) >= limit;

  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid;
  logic          hit;
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[CW:1];
  assign hit     = (pos_q < count_q) && eq_vec[pos_q[IW-1:0]];

  assign busy = state_q != S_IDLE;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    done_d       = 1'b0;
    cmd_d        = cmd_q;
    item_key_d   = item_key_q;
    item_pay_d   = item_pay_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    pos_d        = pos_q;
    st_d         = st_q;
    stop_d       = stop_q;
    lm_d         = lm_q;
    need_rd_d    = need_rd_q;
    need_mv_d    = need_mv_q;
    found_d      = found_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    ctrl         = '0;
    bound        = count_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d      = command_i;
          item_key_d = key_i;
          item_pay_d = payload_i;
          found_d    = '0;
          need_rd_d  = 1'b0;
          need_mv_d  = 1'b0;
          state_d    = S_CMP;
        end
      end
      S_CMP: begin
        ctrl.cmp = 1'b1;
        if (is_ins && full) begin
          done_d       = 1'b1;
          res_status_d = ST_FULL;
          res_pos_d    = PosW'(count_q);
          state_d      = S_IDLE;
        end else if (is_rem && count_q == '0) begin
          done_d       = 1'b1;
          res_status_d = ST_EMPTY;
          res_pos_d    = '0;
          state_d      = S_IDLE;
        end else begin
          lo_d    = '0;
          hi_d    = count_q;
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (ordered_q) begin
          // lower-bound binary search, one probe a cycle
          if (lo_q == hi_q) begin
            pos_d   = lo_q;
            state_d = S_RES;
          end else if (lt_vec[mid[IW-1:0]]) begin
            lo_d = mid + CW'(1);
          end else if (eq_vec[mid[IW-1:0]]) begin
            pos_d   = mid;
            state_d = S_RES;
          end else begin
            hi_d = mid;
          end
        end else begin
          // linear scan from index 0, lo is the scan index
          if (lo_q == count_q) begin
            pos_d   = count_q;
            state_d = S_RES;
          end else if (eq_vec[lo_q[IW-1:0]]) begin
            pos_d   = lo_q;
            state_d = S_RES;
          end else begin
            lo_d = lo_q + CW'(1);
          end
        end
      end
      S_RES: begin
        st_d = '0;
        lm_d = count_q - CW'(1) - pos_q;
        if (is_ins) begin
          if (hit) begin
            done_d       = 1'b1;
            res_status_d = ST_DUP;
            res_pos_d    = PosW'(pos_q);
            state_d      = S_IDLE;
          end else begin
            state_d = S_WR;
          end
        end else if (hit) begin
          need_rd_d = 1'b1;
          need_mv_d = is_rem && !ordered_q;
          stop_d    = pos_q;
          if (is_rem && !ordered_q && (count_q - CW'(1) - pos_q) > pos_q) begin
            stop_d = count_q - CW'(1) - pos_q;
          end
          state_d = S_SCAN;
        end else begin
          done_d       = 1'b1;
          res_status_d = ST_MISS;
          res_pos_d    = PosW'(pos_q);
          state_d      = S_IDLE;
        end
      end
      S_SCAN: begin
        // after st shifts cell j's conveyor word is entry j+st
        ctrl.tok_shift = 1'b1;
        ctrl.mv        = need_mv_q && st_q == lm_q;
        if (need_rd_q && st_q == pos_q) begin
          found_d = c_tok_pay[0];
        end
        if (st_q == stop_q) begin
          if (is_rem) begin
            state_d = S_WR;
          end else begin
            done_d       = 1'b1;
            res_status_d = ST_OK;
            res_pos_d    = PosW'(pos_q);
            state_d      = S_IDLE;
          end
        end else begin
          st_d = st_q + CW'(1);
        end
      end
      S_WR: begin
        done_d       = 1'b1;
        res_status_d = ST_OK;
        res_pos_d    = PosW'(pos_q);
        state_d      = S_IDLE;
        if (is_ins) begin
          // unordered miss leaves pos at count, so this is an append
          ctrl.ins = 1'b1;
          count_d  = count_q + CW'(1);
        end else begin
          ctrl.rem = ordered_q;
          bound    = count_q - CW'(1);
          count_d  = count_q - CW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_cnt_d   = done_d ? PosW'(count_d) : res_cnt_q;
    res_found_d = done_d ? found_d : res_found_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      done_q     <= 1'b0;
      ordered_q  <= 1'b1;
      capacity_q <= CapW'(64);
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ORDERED:  ordered_q  <= cfg_data_i[0];
          CFG_CAPACITY: capacity_q <= cfg_data_i;
          default:      ordered_q  <= ordered_q;
        endcase
      end
    end
  end

  // working and result words
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    item_key_q   <= item_key_d;
    item_pay_q   <= item_pay_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    pos_q        <= pos_d;
    st_q         <= st_d;
    stop_q       <= stop_d;
    lm_q         <= lm_d;
    need_rd_q    <= need_rd_d;
    need_mv_q    <= need_mv_d;
    found_q      <= found_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_cnt_q    <= res_cnt_d;
    res_found_q  <= res_found_d;
  end

  assign done_o          = done_q;
  assign status_o        = res_status_q;
  assign position_o      = res_pos_q;
  assign entry_count_o   = res_cnt_q;
  assign found_payload_o = res_found_q;

  // an accepted command always leaves the idle state
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("command accepted but sequencer stayed idle");

  // the sequencer returns to idle only together with a result
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (busy || done_q))
    else $error("command finished without a result");

  // failed commands never report a payload
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_status_q != ST_OK) |-> res_found_q == '0)
    else $error("payload reported on a failed command");

  // record count never goes past the table depth
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("record count beyond depth");

  // count moves by at most one per command, and only when a result goes out
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> done_q)
    else $error("record count changed without a result");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
  import krt_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  // the spare command code behaves as a search
  localparam logic [CmdW-1:0] CMD_ALT_SEARCH = 2'd3;
  localparam logic [KeyW-1:0] KEY_MAX = {KeyW{1'b1}};
  localparam logic [PayW-1:0] PAY_MAX = {PayW{1'b1}};

  // one command word as the sender presents it
  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [KeyW-1:0] key;
    logic [PayW-1:0] payload;
  } table_cmd_t;

  // one result word as the table returns it
  typedef struct packed {
    logic [StatW-1:0] status;
    logic [PosW-1:0]  position;
    logic [PosW-1:0]  count;
    logic [PayW-1:0]  payload;
  } table_reply_t;

  // expected result plus the command that caused it, for messages
  typedef struct packed {
    table_cmd_t   word;
    table_reply_t reply;
  } pending_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic             start = 1'b0;
  logic             busy;
  logic [CmdW-1:0]  command_i = CMD_SEARCH;
  logic [KeyW-1:0]  key_i = '0;
  logic [PayW-1:0]  payload_i = '0;
  logic             done_o;
  logic [StatW-1:0] status_o;
  logic [PosW-1:0]  position_o;
  logic [PosW-1:0]  entry_count_o;
  logic [PayW-1:0]  found_payload_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CFG_ORDERED;
  logic [CapW-1:0]    cfg_data_i = '0;

  keyed_record_table_sorted_or_unsorted #(
    .DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .key_i          (key_i),
    .payload_i      (payload_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .position_o     (position_o),
    .entry_count_o  (entry_count_o),
    .found_payload_o(found_payload_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // table shadow: its own copy of the records, the count and both registers
  // ---------------------------------------------------------------------------
  logic [KeyW-1:0] shadow_key [TABLE_DEPTH];
  logic [PayW-1:0] shadow_pay [TABLE_DEPTH];
  int unsigned     shadow_count = 0;
  logic            shadow_ordered = 1'b1;
  logic [CapW-1:0] shadow_cap = 7'd64;

  // ordered: lower-bound binary search; unordered: first match or the count
  function automatic int unsigned locate_key(input logic [KeyW-1:0] k);
    int unsigned lo, hi, mid, i;
    lo = 0;
    hi = shadow_count;
    if (!shadow_ordered) begin
      for (i = 0; i < shadow_count; i++)
        if (shadow_key[i] == k) return i;
      return shadow_count;
    end
    while (lo != hi) begin
      mid = (lo + hi) >> 1;
      if (shadow_key[mid] < k) lo = mid + 1;
      else if (shadow_key[mid] > k) hi = mid;
      else return mid;
    end
    return lo;
  endfunction

  // applies one accepted command to the shadow and returns the result it gives
  function automatic table_reply_t apply_table_cmd(input table_cmd_t w);
    table_reply_t r;
    int unsigned  limit, slot, i;
    logic         hit;
    r = '0;
    // a capacity above the depth is clipped, zero blocks every insert
    limit = (shadow_cap < TABLE_DEPTH) ? shadow_cap : TABLE_DEPTH;
    slot = 0;
    hit = 1'b0;
    case (w.cmd)
      CMD_INSERT: begin
        if (shadow_count >= limit) begin
          // also covers a count left above a lowered capacity
          r.status = ST_FULL;
          slot = shadow_count;
        end else begin
          slot = locate_key(w.key);
          hit = (slot < shadow_count) && (shadow_key[slot] == w.key);
          if (hit) begin
            r.status = ST_DUP;
          end else begin
            if (shadow_ordered) begin
              for (i = shadow_count; i > slot; i--) begin
                shadow_key[i] = shadow_key[i-1];
                shadow_pay[i] = shadow_pay[i-1];
              end
            end else begin
              slot = shadow_count;
            end
            shadow_key[slot] = w.key;
            shadow_pay[slot] = w.payload;
            shadow_count++;
            r.status = ST_OK;
          end
        end
      end
      CMD_REMOVE: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          slot = locate_key(w.key);
          hit = (slot < shadow_count) && (shadow_key[slot] == w.key);
          if (hit) begin
            r.payload = shadow_pay[slot];
            shadow_count--;
            if (shadow_ordered) begin
              for (i = slot; i < shadow_count; i++) begin
                shadow_key[i] = shadow_key[i+1];
                shadow_pay[i] = shadow_pay[i+1];
              end
            end else begin
              // the last record fills the hole
              shadow_key[slot] = shadow_key[shadow_count];
              shadow_pay[slot] = shadow_pay[shadow_count];
            end
            r.status = ST_OK;
          end else begin
            r.status = ST_MISS;
          end
        end
      end
      default: begin
        // search, including the spare code
        slot = locate_key(w.key);
        hit = (slot < shadow_count) && (shadow_key[slot] == w.key);
        if (hit) begin
          r.status = ST_OK;
          r.payload = shadow_pay[slot];
        end else begin
          r.status = ST_MISS;
        end
      end
    endcase
    r.position = slot[PosW-1:0];
    r.count = shadow_count[PosW-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // scoreboard state
  // ---------------------------------------------------------------------------
  table_cmd_t     cmd_q [$];     // words waiting for the driver
  pending_reply_t reply_q [$];   // results owed by the table, oldest first
  int unsigned    idle_pct = 0;  // sender idle chance per cycle, in percent
  logic           taken_q = 1'b0;
  int unsigned    n_errors = 0;
  int unsigned    n_accepted = 0;
  int unsigned    n_checked = 0;
  int unsigned    n_settings = 0;
  int unsigned    status_seen [8];

  task automatic report_mismatch(input string msg);
    // printing stops after 100 mismatches so a broken table cannot flood the log
    if (n_errors < 100) $display("%0d ns: %s", $time, msg);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: falling edge, holds a word until the table takes it
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive
    table_cmd_t next_word;
    if (rst_ni && !(start && !taken_q)) begin
      if (cmd_q.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
        next_word = cmd_q.pop_front();
        start <= 1'b1;
        command_i <= next_word.cmd;
        key_i <= next_word.key;
        payload_i <= next_word.payload;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: rising edge, checks results and predicts on each accepted word
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch
    pending_reply_t want;
    table_cmd_t     got_word;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        n_checked++;
        if (!$isunknown(status_o)) status_seen[status_o]++;
        if (reply_q.size() == 0) begin
          report_mismatch($sformatf("result with no command outstanding (status %0d)",
                                    status_o));
        end else begin
          want = reply_q.pop_front();
          if (status_o !== want.reply.status)
            report_mismatch($sformatf("cmd %0d key %h: status %0d, want %0d",
                            want.word.cmd, want.word.key, status_o, want.reply.status));
          if (position_o !== want.reply.position)
            report_mismatch($sformatf("cmd %0d key %h: position %0d, want %0d",
                            want.word.cmd, want.word.key, position_o, want.reply.position));
          if (entry_count_o !== want.reply.count)
            report_mismatch($sformatf("cmd %0d key %h: entry count %0d, want %0d",
                            want.word.cmd, want.word.key, entry_count_o, want.reply.count));
          if (found_payload_o !== want.reply.payload)
            report_mismatch($sformatf("cmd %0d key %h: payload %h, want %h",
                            want.word.cmd, want.word.key, found_payload_o,
                            want.reply.payload));
        end
      end
      taken_q <= start && !busy;
      if (start && !busy) begin
        got_word = '{cmd: command_i, key: key_i, payload: payload_i};
        want.word = got_word;
        want.reply = apply_table_cmd(got_word);
        reply_q.push_back(want);
        n_accepted++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_word(input logic [CmdW-1:0] c, input logic [KeyW-1:0] k,
                           input logic [PayW-1:0] p);
    cmd_q.push_back('{cmd: c, key: k, payload: p});
  endtask

  // keys mostly from a small pool at both ends of the range, so that hits,
  // duplicates and a full table are common; some are fully random
  function automatic logic [KeyW-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 45) return KeyW'($urandom_range(47, 0));
    if (r < 90) return KEY_MAX - KeyW'($urandom_range(47, 0));
    return KeyW'($urandom());
  endfunction

  function automatic logic [CmdW-1:0] pick_cmd(input int unsigned ins_pct,
                                               input int unsigned rem_pct);
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < ins_pct) return CMD_INSERT;
    if (r < ins_pct + rem_pct) return CMD_REMOVE;
    return ($urandom_range(9, 0) == 0) ? CMD_ALT_SEARCH : CMD_SEARCH;
  endfunction

  // table is idle: nothing queued, nothing presented, nothing owed
  task automatic wait_drained();
    while (cmd_q.size() != 0 || start || reply_q.size() != 0 || busy)
      @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CapW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == CFG_ORDERED) shadow_ordered = data[0];
    else shadow_cap = data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one table setting: optional emptying pass, register writes, random words
  task automatic run_phase(input logic ordered, input logic [CapW-1:0] cap,
                           input int unsigned idle, input int unsigned n,
                           input int unsigned ins_pct, input int unsigned rem_pct,
                           input bit empty_first);
    logic [KeyW-1:0] stored [$];
    int unsigned     i;
    wait_drained();
    idle_pct = idle;
    if (empty_first) begin
      // linear removes of every stored key empty the table even when
      // duplicates crept in while the data was unsorted
      write_reg(CFG_ORDERED, 7'd0);
      for (i = 0; i < shadow_count; i++) stored.push_back(shadow_key[i]);
      foreach (stored[j]) push_word(CMD_REMOVE, stored[j], $urandom());
      wait_drained();
    end
    write_reg(CFG_ORDERED, {6'd0, ordered});
    write_reg(CFG_CAPACITY, cap);
    n_settings++;
    for (i = 0; i < n; i++)
      push_word(pick_cmd(ins_pct, rem_pct), pick_key(), $urandom());
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed words on the reset setting (sorted, capacity 64)
    n_settings++;
    push_word(CMD_SEARCH, 31'd5, '0);              // search on an empty table
    push_word(CMD_REMOVE, 31'd5, PAY_MAX);         // remove on an empty table
    push_word(CMD_INSERT, KEY_MAX, PAY_MAX);
    push_word(CMD_INSERT, 31'd0, '0);
    push_word(CMD_INSERT, 31'd1000, 32'hA5A5_A5A5);
    push_word(CMD_INSERT, 31'd1000, 32'h0000_0001); // duplicate key
    push_word(CMD_SEARCH, 31'd0, PAY_MAX);
    push_word(CMD_SEARCH, KEY_MAX, '0);
    push_word(CMD_SEARCH, 31'd999, '0);            // miss gives the insertion point
    push_word(CMD_ALT_SEARCH, 31'd1000, '0);       // spare code acts as a search
    push_word(CMD_INSERT, 31'd500, 32'h5A5A_5A5A);
    push_word(CMD_INSERT, 31'd2000, 32'h8000_0000);
    push_word(CMD_REMOVE, 31'd1000, '0);           // hit in the middle
    push_word(CMD_REMOVE, 31'd1000, '0);           // remove miss
    push_word(CMD_REMOVE, 31'd0, '0);              // first record
    push_word(CMD_REMOVE, KEY_MAX, '0);            // last record
    push_word(CMD_INSERT, KEY_MAX - 31'd1, 32'h7FFF_FFFF);
    push_word(CMD_ALT_SEARCH, 31'h2AAA_AAAA, '0);
    push_word(CMD_SEARCH, 31'h5555_5555, '0);

    // sorted, filling up to the full depth
    run_phase(1'b1, 7'd64, 0, 300, 60, 15, 1'b0);
    // switch to unsorted with records present
    run_phase(1'b0, 7'd64, 67, 300, 35, 35, 1'b0);
    // back to sorted on unsorted data, capacity lowered below the count
    run_phase(1'b1, 7'd5, 22, 200, 30, 45, 1'b0);
    // emptied, unsorted with room for one record
    run_phase(1'b0, 7'd1, 0, 150, 40, 30, 1'b1);
    // capacity zero: every insert is refused
    run_phase(1'b1, 7'd0, 67, 100, 50, 20, 1'b0);
    // capacity above the depth is clipped to it
    run_phase(1'b1, 7'd127, 22, 300, 55, 20, 1'b0);
    run_phase(1'b0, 7'd100, 67, 250, 40, 35, 1'b0);
    // emptied, sorted with half the depth
    run_phase(1'b1, 7'd32, 0, 200, 45, 30, 1'b1);

    wait_drained();
    // any stray result would show up within the longest command time
    repeat (2 * TABLE_DEPTH + 10) @(posedge clk_i);

    $display("%0d commands checked over %0d table settings, sorted and unsorted,",
             n_checked, n_settings);
    $display("capacity 0 to 127; ok %0d, full %0d, empty %0d, duplicate %0d, miss %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_DUP], status_seen[ST_MISS]);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #15ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* sim.f */
rtl/krt_pkg.sv
rtl/krt_cell.sv
rtl/keyed_record_table_sorted_or_unsorted.sv
bench/tb.sv
